// ===== design/kfcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kfcl_pkg
// Shared types and constants for the keyframe clock locator.
// ----------------------------------------------------------------------------
`default_nettype none
package kfcl_pkg;

    localparam int TimeW  = 32;
    localparam int DeltaW = 24;
    localparam int SpeedW = 16;
    localparam int FracW  = 20;
    localparam int CfgW   = 32;
    localparam int IdxW   = 8;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] REG_COUNT  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_LENGTH = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SPEED  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_LOOP   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_WEIGHT = 3'd4;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    localparam logic signed [FracW-1:0] FRAC_MAX = 20'sh7FFFF;
    localparam logic signed [FracW-1:0] FRAC_MIN = -20'sh80000;

    typedef struct packed {
        logic               func;
        logic [IdxW-1:0]    entry_index;
        logic [TimeW-1:0]   entry_time;
        logic [DeltaW-1:0]  delta_time;
    } in_item_t;

    typedef struct packed {
        logic                     located;
        logic [IdxW-1:0]          start_index;
        logic [IdxW-1:0]          end_index;
        logic signed [FracW-1:0]  blend_fraction;
        logic [TimeW-1:0]         current_time;
    } out_item_t;

endpackage
`default_nettype wire

// ===== design/kfcl_queue.sv =====
// ----------------------------------------------------------------------------
// kfcl_queue
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module kfcl_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire kfcl_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output kfcl_pkg::in_item_t      out_data
);
    kfcl_pkg::in_item_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== design/kfcl_back.sv =====
// ----------------------------------------------------------------------------
// kfcl_back
// Executes requests: table writes, clock advance, search and fraction divide.
// ----------------------------------------------------------------------------
`default_nettype none
module kfcl_back #(
    parameter int MAX_KEYFRAMES  = 256,
    parameter int TIME_FRAC_BITS = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire kfcl_pkg::in_item_t         req,
    input  wire logic [8:0]                 keyframe_count,
    input  wire logic [kfcl_pkg::TimeW-1:0] clip_length,
    input  wire logic signed [kfcl_pkg::SpeedW-1:0] play_speed,
    input  wire logic                       loop_enable,
    input  wire logic [15:0]                blend_weight,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output kfcl_pkg::out_item_t             m_data
);
    localparam int AW   = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
    localparam int CW   = AW + 1;
    localparam int TW   = kfcl_pkg::TimeW;
    localparam int DW   = TW + 1;            // divider width
    localparam int QB   = DW + TIME_FRAC_BITS; // dividend and quotient bits
    localparam int IW   = kfcl_pkg::IdxW;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_MUL   = 12'b000000000010,
        ST_ADD   = 12'b000000000100,
        ST_MOD   = 12'b000000001000,
        ST_RD0   = 12'b000000010000,
        ST_CHK0  = 12'b000000100000,
        ST_SRCH  = 12'b000001000000,
        ST_SWAIT = 12'b000010000000,
        ST_RDS   = 12'b000100000000,
        ST_RDE   = 12'b001000000000,
        ST_DIV   = 12'b010000000000,
        ST_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg;
    logic [TW-1:0]        table_mem [MAX_KEYFRAMES];
    logic [AW-1:0]        rd_addr;
    logic [TW-1:0]        rd_data_reg;

    logic [TW-1:0]        play_reg;
    logic signed [41:0]   prod_reg;
    logic signed [34:0]   sum_reg;
    logic [34:0]          rem_reg;      // serial modulo remainder
    logic [5:0]           bit_reg;
    logic [CW-1:0]        count_reg, lo_reg, hi_reg;
    logic [AW-1:0]        s_reg, e_reg;
    logic [TW-1:0]        ts_reg;
    logic                 neg_reg;
    logic [QB-1:0]        dnum_reg;     // dividend shifting out
    logic [DW:0]          drem_reg;
    logic [DW-1:0]        dden_reg;
    logic [QB-1:0]        quo_reg;
    logic                 out_valid_reg;
    kfcl_pkg::out_item_t  out_reg;

    logic [CW-1:0]        mid;
    logic [CW-1:0]        cnt_sat;
    logic signed [34:0]   step_w;
    logic [DW:0]          drem_sh;
    logic [35:0]          mod_sh;
    logic [CW-1:0]        lo_m1;

    assign cnt_sat = (keyframe_count > 9'(MAX_KEYFRAMES)) ? CW'(MAX_KEYFRAMES)
                                                           : CW'(keyframe_count);
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign step_w  = 35'(prod_reg >>> 8);
    assign drem_sh = {drem_reg[DW-1:0], dnum_reg[QB-1]};
    assign mod_sh  = {rem_reg, sum_reg[6'(34) - bit_reg]};
    assign lo_m1   = (lo_reg != '0) ? lo_reg - 1'b1 : '0;

    always_comb begin
        unique case (state_reg)
            ST_SRCH: rd_addr = mid[AW-1:0];
            ST_RDS:  rd_addr = s_reg;
            ST_RDE:  rd_addr = e_reg;
            default: rd_addr = '0;
        endcase
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        rd_data_reg <= table_mem[rd_addr];
        if (req_valid && req_ready && req.func == kfcl_pkg::FUNC_WRITE
            && 32'(req.entry_index) < 32'(MAX_KEYFRAMES)) begin
            table_mem[req.entry_index[AW-1:0]] <= req.entry_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            play_reg      <= '0;
        end else begin
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (req_valid && req_ready && req.func == kfcl_pkg::FUNC_STEP) begin
                        prod_reg  <= $signed({1'b0, req.delta_time}) * play_speed;
                        count_reg <= cnt_sat;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // floor shift rounds toward minus infinity
                    sum_reg   <= $signed({3'b0, play_reg}) +
                                 ((blend_weight != '0) ? step_w : 35'sd0);
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    if (blend_weight == '0) begin
                        state_reg <= ST_RD0;
                    end else if (loop_enable && clip_length != '0) begin
                        rem_reg   <= '0;
                        bit_reg   <= '0;
                        neg_reg   <= sum_reg[34];
                        if (sum_reg[34]) sum_reg <= -sum_reg;
                        state_reg <= ST_MOD;
                    end else begin
                        if (sum_reg[34]) play_reg <= '0;
                        else if (sum_reg[33:0] > {2'b0, clip_length}) play_reg <= clip_length;
                        else play_reg <= sum_reg[31:0];
                        state_reg <= ST_RD0;
                    end
                end
                ST_MOD: begin
                    // restoring remainder, one dividend bit per cycle
                    if (mod_sh >= {4'b0, clip_length}) rem_reg <= 35'(mod_sh - {4'b0, clip_length});
                    else rem_reg <= mod_sh[34:0];
                    if (bit_reg == 6'd34) begin
                        bit_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_RD0;
                        if (mod_sh >= {4'b0, clip_length}) begin
                            play_reg <= (neg_reg && (mod_sh[31:0] != clip_length))
                                ? clip_length - 32'(mod_sh - {4'b0, clip_length})
                                : 32'(mod_sh - {4'b0, clip_length});
                        end else begin
                            play_reg <= (neg_reg && mod_sh[31:0] != '0)
                                ? clip_length - mod_sh[31:0] : mod_sh[31:0];
                        end
                    end else begin
                        bit_reg <= bit_reg + 1'b1;
                    end
                end
                ST_RD0: begin
                    if (count_reg == '0) begin
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_CHK0;   // read of slot 0 in flight
                    end
                end
                ST_CHK0: begin
                    if (rd_data_reg >= play_reg) begin
                        s_reg     <= AW'(count_reg - 1'b1);
                        e_reg     <= '0;
                        state_reg <= ST_RDS;
                    end else begin
                        lo_reg    <= '0;
                        hi_reg    <= count_reg - 1'b1;
                        state_reg <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    if (lo_reg < hi_reg) state_reg <= ST_SWAIT;
                    else begin
                        s_reg     <= AW'(lo_m1);
                        e_reg     <= AW'(lo_reg);
                        state_reg <= ST_RDS;
                    end
                end
                ST_SWAIT: begin
                    if (rd_data_reg <= play_reg) lo_reg <= mid + 1'b1;
                    else hi_reg <= mid;
                    state_reg <= ST_SRCH;
                end
                ST_RDS: state_reg <= ST_RDE;
                ST_RDE: begin
                    ts_reg    <= rd_data_reg;
                    state_reg <= ST_DIV;
                    bit_reg   <= '0;
                end
                ST_DIV: begin
                    if (bit_reg == '0) begin
                        // rd_data_reg now holds end time
                        logic [DW-1:0] n_abs, d_abs;
                        logic n_neg, d_neg;
                        n_neg = play_reg < ts_reg;
                        d_neg = rd_data_reg < ts_reg;
                        n_abs = n_neg ? DW'(ts_reg - play_reg) : DW'(play_reg - ts_reg);
                        d_abs = d_neg ? DW'(ts_reg - rd_data_reg) : DW'(rd_data_reg - ts_reg);
                        neg_reg  <= n_neg ^ d_neg;
                        dden_reg <= d_abs;
                        dnum_reg <= {n_abs, TIME_FRAC_BITS'(0)};
                        drem_reg <= '0;
                        quo_reg  <= '0;
                        bit_reg  <= 6'd1;
                    end else begin
                        dnum_reg <= dnum_reg << 1;
                        if (drem_sh >= {1'b0, dden_reg}) begin
                            drem_reg <= drem_sh - {1'b0, dden_reg};
                            quo_reg  <= {quo_reg[QB-2:0], 1'b1};
                        end else begin
                            drem_reg <= drem_sh;
                            quo_reg  <= {quo_reg[QB-2:0], 1'b0};
                        end
                        bit_reg <= bit_reg + 1'b1;
                        if (bit_reg == 6'(QB)) begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (!out_valid_reg) begin
                        if (count_reg != '0) begin
                            logic signed [kfcl_pkg::FracW-1:0] f;
                            if (dden_reg == '0) f = '0;
                            else if (!neg_reg)
                                f = (quo_reg > QB'(kfcl_pkg::FRAC_MAX)) ? kfcl_pkg::FRAC_MAX
                                    : kfcl_pkg::FracW'(quo_reg);
                            else
                                f = (quo_reg > QB'(20'h80000)) ? kfcl_pkg::FRAC_MIN
                                    : -kfcl_pkg::FracW'(quo_reg);
                            out_reg <= '{located: 1'b1,
                                         start_index: IW'(s_reg), end_index: IW'(e_reg),
                                         blend_fraction: f, current_time: play_reg};
                        end else begin
                            out_reg <= '{located: 1'b0, start_index: '0, end_index: '0,
                                         blend_fraction: '0, current_time: play_reg};
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/keyframe_clock_locator.sv =====
// ----------------------------------------------------------------------------
// keyframe_clock_locator
// Playback clock with keyframe bracket search and inverse-lerp fraction.
// ----------------------------------------------------------------------------
// A step request runs a serial modulo when the clock wraps and skips it when
// it clamps or is frozen; a search probe is a table read in ST_SRCH and a
// compare in ST_SWAIT, and the fraction divider is serial. A zero count skips
// search and divide. Writes take effect as accepted and give no result. One
// request is worked at a time, the queue holds two more, and a held result
// does not stop the next request from being worked, but its result waits in
// ST_OUT until the held one is taken. Reset (aresetn, synchronous): clock to
// zero, registers to defaults; the keyframe table is not cleared.
`default_nettype none
module keyframe_clock_locator #(
    parameter int MAX_KEYFRAMES  = 256,
    parameter int TIME_FRAC_BITS = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire kfcl_pkg::in_item_t        s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output kfcl_pkg::out_item_t            m_data,
    input  wire logic                      cfg_we,
    input  wire logic [kfcl_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [kfcl_pkg::CfgW-1:0] cfg_data
);
    // configuration registers
    logic [8:0]  count_reg;
    logic [31:0] length_reg;
    logic [15:0] speed_reg;
    logic        loop_reg;
    logic [15:0] weight_reg;

    logic               q_valid, q_ready;
    kfcl_pkg::in_item_t q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            length_reg <= '0;
            speed_reg  <= 16'd256;
            loop_reg   <= 1'b1;
            weight_reg <= 16'hFFFF;
        end else if (cfg_we) begin
            unique case (cfg_index)
                kfcl_pkg::REG_COUNT:  count_reg  <= cfg_data[8:0];
                kfcl_pkg::REG_LENGTH: length_reg <= cfg_data;
                kfcl_pkg::REG_SPEED:  speed_reg  <= cfg_data[15:0];
                kfcl_pkg::REG_LOOP:   loop_reg   <= cfg_data[0];
                kfcl_pkg::REG_WEIGHT: weight_reg <= cfg_data[15:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // front: buffer requests so the back stalls on its own
    kfcl_queue u_queue (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready), .in_data(s_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    // back: execute writes and steps
    kfcl_back #(.MAX_KEYFRAMES(MAX_KEYFRAMES), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_back (
        .aclk, .aresetn,
        .req_valid(q_valid), .req_ready(q_ready), .req(q_data),
        .keyframe_count(count_reg), .clip_length(length_reg),
        .play_speed($signed(speed_reg)), .loop_enable(loop_reg),
        .blend_weight(weight_reg),
        .m_valid, .m_ready, .m_data
    );
endmodule
`default_nettype wire
